// File: design/pidf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// PID step package
// Types, operation codes and saturation helper shared by the PID step unit.
// ----------------------------------------------------------------------------
package pidf_pkg;

	localparam int DATA_W  = 32;
	localparam int COEF_W  = 31;
	localparam int ALPHA_W = 17;
	localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;

	localparam logic [2:0] REG_KP    = 3'd0;
	localparam logic [2:0] REG_KI    = 3'd1;
	localparam logic [2:0] REG_KD    = 3'd2;
	localparam logic [2:0] REG_ILIM  = 3'd3;
	localparam logic [2:0] REG_ALPHA_T = 3'd4;
	localparam logic [2:0] REG_ALPHA_E = 3'd5;
	localparam logic [2:0] REG_ALPHA_D = 3'd6;
	localparam logic [2:0] REG_INV   = 3'd7;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_T_SET, OP_T_ACC, OP_E_SET, OP_E_ACC,
		OP_DV_SET, OP_DV_ACC, OP_DF_SET, OP_DF_ACC, OP_I_DEC, OP_I_SET,
		OP_I_ACC, OP_P_SET, OP_P_ACC, OP_D_SET, OP_D_ACC, OP_OUT
	} op_t;

	typedef enum logic [4:0] {
		S_IDLE, S_T_SET, S_T_ACC, S_E_SET, S_E_ACC, S_DV_SET, S_DV_ACC,
		S_DF_SET, S_DF_ACC, S_I_DEC, S_I_SET, S_I_ACC, S_P_SET, S_P_ACC,
		S_D_SET, S_D_ACC, S_MUL, S_OUT
	} state_t;

	typedef struct packed {
		logic [COEF_W-1:0]  kp;
		logic [COEF_W-1:0]  ki;
		logic [COEF_W-1:0]  kd;
		logic [COEF_W-1:0]  ilim;
		logic [ALPHA_W-1:0] alpha_t;
		logic [ALPHA_W-1:0] alpha_e;
		logic [ALPHA_W-1:0] alpha_d;
		logic [COEF_W-1:0]  inv;
	} cfg_t;

	typedef struct packed {
		logic first;
		logic emode_in;
		logic inv_nz;
		logic i_en;
		logic i_upd;
	} status_t;

	function automatic logic signed [DATA_W-1:0] sat34(input logic signed [DATA_W+1:0] v);
		logic signed [DATA_W-1:0] r;
		if (v[DATA_W+1:DATA_W-1] == 3'b000 || v[DATA_W+1:DATA_W-1] == 3'b111) begin
			r = v[DATA_W-1:0];
		end else if (v[DATA_W+1]) begin
			r = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(DATA_W-1){1'b1}}};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// File: design/pidf_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// PID step channels
// Sample and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pidf_in_if;
	logic               valid;
	logic               ready;
	logic               error_mode;
	logic signed [31:0] target;
	logic signed [31:0] measurement;
	logic signed [31:0] error_in;
	logic               limit_active;
	logic               clear_integrator;
	modport source(output valid, error_mode, target, measurement, error_in,
		limit_active, clear_integrator, input ready);
	modport sink(input valid, error_mode, target, measurement, error_in,
		limit_active, clear_integrator, output ready);
endinterface

interface pidf_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] drive;
	logic signed [31:0] p_term;
	logic signed [31:0] i_term;
	logic signed [31:0] d_term;
	logic signed [31:0] filtered_target;
	logic signed [31:0] filtered_error;
	modport source(output valid, drive, p_term, i_term, d_term, filtered_target,
		filtered_error, input ready);
	modport sink(input valid, drive, p_term, i_term, d_term, filtered_target,
		filtered_error, output ready);
endinterface
`default_nettype wire

// File: design/pidf_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// PID step controller
// Sequences the datapath operations of one sample and owns the handshakes.
// ----------------------------------------------------------------------------
module pidf_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	input  wire               out_ready,
	input  pidf_pkg::status_t stat,
	output pidf_pkg::op_t     op,
	output logic              in_ready,
	output logic              out_valid
);
	import pidf_pkg::*;

	state_t state_q, state_d, ret_q, ret_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (stat.first) state_d = S_I_DEC;
					else if (stat.emode_in) state_d = S_E_SET;
					else state_d = S_T_SET;
				end
			end
			S_T_SET:  begin state_d = S_MUL; ret_d = S_T_ACC; end
			S_T_ACC:  state_d = S_E_SET;
			S_E_SET:  begin state_d = S_MUL; ret_d = S_E_ACC; end
			S_E_ACC:  state_d = stat.inv_nz ? S_DV_SET : S_I_DEC;
			S_DV_SET: begin state_d = S_MUL; ret_d = S_DV_ACC; end
			S_DV_ACC: state_d = S_DF_SET;
			S_DF_SET: begin state_d = S_MUL; ret_d = S_DF_ACC; end
			S_DF_ACC: state_d = S_I_DEC;
			S_I_DEC:  state_d = (stat.i_en && stat.i_upd) ? S_I_SET : S_P_SET;
			S_I_SET:  begin state_d = S_MUL; ret_d = S_I_ACC; end
			S_I_ACC:  state_d = S_P_SET;
			S_P_SET:  begin state_d = S_MUL; ret_d = S_P_ACC; end
			S_P_ACC:  state_d = S_D_SET;
			S_D_SET:  begin state_d = S_MUL; ret_d = S_D_ACC; end
			S_D_ACC:  state_d = S_OUT;
			S_MUL:    state_d = ret_q;
			S_OUT:    if (out_free) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		op       = OP_NONE;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) op = OP_LOAD;
			end
			S_T_SET:  op = OP_T_SET;
			S_T_ACC:  op = OP_T_ACC;
			S_E_SET:  op = OP_E_SET;
			S_E_ACC:  op = OP_E_ACC;
			S_DV_SET: op = OP_DV_SET;
			S_DV_ACC: op = OP_DV_ACC;
			S_DF_SET: op = OP_DF_SET;
			S_DF_ACC: op = OP_DF_ACC;
			S_I_DEC:  op = OP_I_DEC;
			S_I_SET:  op = OP_I_SET;
			S_I_ACC:  op = OP_I_ACC;
			S_P_SET:  op = OP_P_SET;
			S_P_ACC:  op = OP_P_ACC;
			S_D_SET:  op = OP_D_SET;
			S_D_ACC:  op = OP_D_ACC;
			S_OUT:    if (out_free) op = OP_OUT;
			default:  op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			if (op == OP_OUT) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

// File: design/pidf_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// PID step datapath
// Filter, integrator and term registers around one shared saturating multiplier.
// ----------------------------------------------------------------------------
module pidf_datapath (
	input  wire                clk,
	input  wire                arst_n,
	input  pidf_pkg::op_t      op,
	input  pidf_pkg::cfg_t     cfg,
	input  wire                error_mode,
	input  wire signed [31:0]  target,
	input  wire signed [31:0]  measurement,
	input  wire signed [31:0]  error_in,
	input  wire                limit_active,
	input  wire                clear_integrator,
	output pidf_pkg::status_t  stat,
	output logic signed [31:0] drive,
	output logic signed [31:0] p_term,
	output logic signed [31:0] i_term,
	output logic signed [31:0] d_term,
	output logic signed [31:0] filtered_target,
	output logic signed [31:0] filtered_error
);
	import pidf_pkg::*;

	logic               first_q, emode_q, limit_q;
	logic signed [31:0] tgt_q, meas_q, edir_q;
	logic signed [31:0] tf_q, ef_q, df_q, integ_q, last_q, dv_q, p_q, d_q;
	logic signed [32:0] a_q;
	logic [30:0]        b_q;
	logic signed [31:0] prod_q;

	logic [32:0]        mag;
	logic [63:0]        full;
	logic [47:0]        tr, tc;
	logic signed [31:0] mul_r;
	logic signed [31:0] e_val, isum, ilim_p, ilim_n;

	function automatic logic signed [33:0] x34(input logic signed [31:0] v);
		return {{2{v[31]}}, v};
	endfunction

	function automatic logic signed [32:0] x33(input logic signed [31:0] v);
		return {v[31], v};
	endfunction

	function automatic logic [30:0] clip_alpha(input logic [16:0] a);
		return (a > ALPHA_ONE) ? {14'd0, ALPHA_ONE} : {14'd0, a};
	endfunction

	always_comb begin
		mag  = a_q[32] ? 33'(-a_q) : 33'(a_q);
		full = 64'(mag) * 64'(b_q);
		tr   = full[63:16];
		if (a_q[32]) begin
			tc    = (tr > 48'h8000_0000) ? 48'h8000_0000 : tr;
			mul_r = -$signed(tc[31:0]);
		end else begin
			tc    = (tr > 48'h7FFF_FFFF) ? 48'h7FFF_FFFF : tr;
			mul_r = $signed(tc[31:0]);
		end
	end

	assign e_val  = emode_q ? edir_q : sat34(x34(tf_q) - x34(meas_q));
	assign isum   = sat34(x34(integ_q) + x34(prod_q));
	assign ilim_p = $signed({1'b0, cfg.ilim});
	assign ilim_n = -ilim_p;

	assign stat.first    = first_q;
	assign stat.emode_in = error_mode;
	assign stat.inv_nz   = (cfg.inv != '0);
	assign stat.i_en     = (cfg.ki != '0) && (cfg.inv != '0);
	assign stat.i_upd    = !limit_q || (integ_q > 0 && ef_q < 0) || (integ_q < 0 && ef_q > 0);

	always_ff @(posedge clk) begin
		prod_q <= mul_r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
			tf_q    <= '0;
			ef_q    <= '0;
			df_q    <= '0;
			integ_q <= '0;
		end else begin
			case (op)
				OP_LOAD: begin
					if (clear_integrator) integ_q <= '0;
					if (first_q) begin
						first_q <= 1'b0;
						df_q    <= '0;
						if (error_mode) begin
							tf_q <= '0;
							ef_q <= error_in;
						end else begin
							tf_q <= target;
							ef_q <= sat34(x34(target) - x34(measurement));
						end
					end else if (error_mode) begin
						tf_q <= '0;
					end
				end
				OP_T_ACC:  tf_q <= sat34(x34(tf_q) + x34(prod_q));
				OP_E_ACC:  ef_q <= sat34(x34(ef_q) + x34(prod_q));
				OP_DF_ACC: df_q <= sat34(x34(df_q) + x34(prod_q));
				OP_I_DEC:  if (!stat.i_en) integ_q <= '0;
				OP_I_ACC: begin
					if (isum > ilim_p) integ_q <= ilim_p;
					else if (isum < ilim_n) integ_q <= ilim_n;
					else integ_q <= isum;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				emode_q <= error_mode;
				limit_q <= limit_active;
				tgt_q   <= target;
				meas_q  <= measurement;
				edir_q  <= error_in;
			end
			OP_T_SET: begin
				a_q <= x33(tgt_q) - x33(tf_q);
				b_q <= clip_alpha(cfg.alpha_t);
			end
			OP_E_SET: begin
				a_q    <= x33(e_val) - x33(ef_q);
				b_q    <= clip_alpha(cfg.alpha_e);
				last_q <= ef_q;
			end
			OP_DV_SET: begin
				a_q <= x33(ef_q) - x33(last_q);
				b_q <= cfg.inv;
			end
			OP_DV_ACC: dv_q <= prod_q;
			OP_DF_SET: begin
				a_q <= x33(dv_q) - x33(df_q);
				b_q <= clip_alpha(cfg.alpha_d);
			end
			OP_I_SET: begin
				a_q <= x33(ef_q);
				b_q <= cfg.ki;
			end
			OP_P_SET: begin
				a_q <= x33(ef_q);
				b_q <= cfg.kp;
			end
			OP_P_ACC: p_q <= prod_q;
			OP_D_SET: begin
				a_q <= x33(df_q);
				b_q <= cfg.kd;
			end
			OP_D_ACC: d_q <= prod_q;
			OP_OUT: begin
				drive           <= sat34(x34(p_q) + x34(integ_q) + x34(d_q));
				p_term          <= p_q;
				i_term          <= integ_q;
				d_term          <= d_q;
				filtered_target <= tf_q;
				filtered_error  <= ef_q;
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// File: design/pid_step_with_input_filters_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// PID step with input filters
// Filtered PID controller step with anti-windup, Q16.16, APB configuration.
// ----------------------------------------------------------------------------
// A sample runs the target filter (target mode only), the error filter, the
// derivative and its filter (unless the inverse step is zero), the integrator
// update (unless held) and the P and D terms; the first sample skips the
// filters and derivative. One sample at a time; the shared multiplier serves
// up to seven products. A waiting result holds the unit until it is taken.
// Reset clears the filters and integrator, arms first-sample loading and
// returns the coefficients to their reset values.
module pid_step_with_input_filters_unit (
	input  wire         clk,
	input  wire         arst_n,
	pidf_in_if.sink     sample,
	pidf_out_if.source  result,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [4:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import pidf_pkg::*;

	cfg_t    cfg_q;
	op_t     op;
	status_t stat;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign idx    = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp      <= '0;
			cfg_q.ki      <= '0;
			cfg_q.kd      <= '0;
			cfg_q.ilim    <= '0;
			cfg_q.alpha_t <= ALPHA_ONE;
			cfg_q.alpha_e <= ALPHA_ONE;
			cfg_q.alpha_d <= ALPHA_ONE;
			cfg_q.inv     <= '0;
		end else if (psel && penable && pwrite) begin
			case (idx)
				REG_KP:      cfg_q.kp      <= pwdata[30:0];
				REG_KI:      cfg_q.ki      <= pwdata[30:0];
				REG_KD:      cfg_q.kd      <= pwdata[30:0];
				REG_ILIM:    cfg_q.ilim    <= pwdata[30:0];
				REG_ALPHA_T: cfg_q.alpha_t <= pwdata[16:0];
				REG_ALPHA_E: cfg_q.alpha_e <= pwdata[16:0];
				REG_ALPHA_D: cfg_q.alpha_d <= pwdata[16:0];
				REG_INV:     cfg_q.inv     <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_KP:      prdata = {1'b0, cfg_q.kp};
			REG_KI:      prdata = {1'b0, cfg_q.ki};
			REG_KD:      prdata = {1'b0, cfg_q.kd};
			REG_ILIM:    prdata = {1'b0, cfg_q.ilim};
			REG_ALPHA_T: prdata = {15'd0, cfg_q.alpha_t};
			REG_ALPHA_E: prdata = {15'd0, cfg_q.alpha_e};
			REG_ALPHA_D: prdata = {15'd0, cfg_q.alpha_d};
			REG_INV:     prdata = {1'b0, cfg_q.inv};
			default:     prdata = '0;
		endcase
	end

	pidf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.out_ready (result.ready),
		.stat      (stat),
		.op        (op),
		.in_ready  (sample.ready),
		.out_valid (result.valid)
	);

	pidf_datapath u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.op               (op),
		.cfg              (cfg_q),
		.error_mode       (sample.error_mode),
		.target           (sample.target),
		.measurement      (sample.measurement),
		.error_in         (sample.error_in),
		.limit_active     (sample.limit_active),
		.clear_integrator (sample.clear_integrator),
		.stat             (stat),
		.drive            (result.drive),
		.p_term           (result.p_term),
		.i_term           (result.i_term),
		.d_term           (result.d_term),
		.filtered_target  (result.filtered_target),
		.filtered_error   (result.filtered_error)
	);

endmodule
`default_nettype wire
